// ===== hdl/ctc_pkg.sv =====
package ctc_pkg;

   localparam int unsigned MAX_ERROR_W = 30;
   localparam int unsigned INTERVAL_W  = 40;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 40;

   localparam logic [MAX_ERROR_W-1:0] MAX_ERROR_RESET = 30'd1000000;
   localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET  = 40'd3000000000;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ERROR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL  = 1'b1;

   localparam logic [1:0] FUNC_CONVERT = 2'd0;
   localparam logic [1:0] FUNC_INIT    = 2'd1;
   localparam logic [1:0] FUNC_CALIB   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_NOT_READY   = 3'd1;
   localparam logic [2:0] STS_UNAVAILABLE = 3'd2;
   localparam logic [2:0] STS_BEFORE_BASE = 3'd3;
   localparam logic [2:0] STS_NOT_DUE     = 3'd4;
   localparam logic [2:0] STS_REJECTED    = 3'd5;

   typedef enum logic [1:0] {
      MODE_UNINIT  = 2'd0,
      MODE_READY   = 2'd2,
      MODE_UNAVAIL = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_MUL, S_CONV, S_PRED, S_ERR, S_CLAMP, S_CORR,
      S_CORR_CHK, S_DIV_SCALE, S_SCALE_CHK, S_DIV_DUE, S_DUE, S_SEND
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_MUL_CONV, OP_MUL_CAL, OP_CONV_RES, OP_PRED, OP_ERR,
      OP_CLAMP, OP_CORR, OP_DIV_INIT, OP_DIV_CAL, OP_COMMIT_INIT, OP_COMMIT_CAL,
      OP_DUE, OP_FAIL, OP_STATUS, OP_SEND
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      mode_type   mode;
      logic       below_base;
      logic       below_due;
      logic       sample_bad;
      logic       init_bad;
      logic       corr_bad;
      logic       quo_zero;
      logic       busy;
      logic       rsp_free;
   } stat_type;

endpackage

// ===== hdl/ctc_if.sv =====
interface ctc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [63:0] counter;
   logic [63:0] first_count;
   logic signed [63:0] first_time;
   logic [63:0] sample_count;
   logic signed [63:0] sample_time;
   logic        sample_ok;
   logic        invariant_ok;

   modport source (output valid, func, counter, first_count, first_time, sample_count,
                   sample_time, sample_ok, invariant_ok, input ready);
   modport sink (input valid, func, counter, first_count, first_time, sample_count,
                 sample_time, sample_ok, invariant_ok, output ready);
endinterface

interface ctc_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] time_ns;
   logic [2:0]  status;
   logic        clock_ready;

   modport source (output valid, time_ns, status, clock_ready, input ready);
   modport sink (input valid, time_ns, status, clock_ready, output ready);
endinterface

// ===== hdl/ctc_mul.sv =====
module ctc_mul #(
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        busy,
   output logic [63:0] result
);

   logic         busy_ff, busy_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in;
   logic [127:0] p_ff, p_in;
   logic [64:0]  sum;

   // shift-add, one multiplier bit per cycle, low half holds the multiplier
   always_comb begin
      sum     = p_ff[0] ? ({1'b0, p_ff[127:64]} + {1'b0, a_ff}) : {1'b0, p_ff[127:64]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         a_in    = a;
         p_in    = {64'd0, b};
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[63:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      p_ff   <= p_in;
   end

   assign busy   = busy_ff;
   assign result = p_ff[FRACTION_BITS +: 64];

endmodule

// ===== hdl/ctc_div.sv =====
module ctc_div #(
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] d,
   output logic        busy,
   output logic [63:0] quo
);

   logic         busy_ff, busy_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  d_ff, d_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic [127:0] num_ff, num_in;
   logic [64:0]  r2;
   logic [64:0]  diff;
   logic         ge;

   // restoring division of (x << FRACTION_BITS) by d, one bit a cycle
   always_comb begin
      r2      = {rem_ff, num_ff[127]};
      diff    = r2 - {1'b0, d_ff};
      ge      = (r2 >= {1'b0, d_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      num_in  = num_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd127;
         d_in    = d;
         rem_in  = 64'd0;
         q_in    = 64'd0;
         num_in  = {64'd0, x} << FRACTION_BITS;
      end else if (busy_ff) begin
         rem_in = ge ? diff[63:0] : r2[63:0];
         q_in   = {q_ff[62:0], ge};
         num_in = {num_ff[126:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      num_ff <= num_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff;

endmodule

// ===== hdl/ctc_ctrl.sv =====
module ctc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ctc_pkg::stat_type stat,
   output ctc_pkg::cmd_type  cmd
);

   ctc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = ctc_pkg::OP_NONE;
      cmd.code  = ctc_pkg::STS_OK;
      unique case (state_ff)
         ctc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = ctc_pkg::OP_LATCH;
               state_in = ctc_pkg::S_DECODE;
            end
         end
         ctc_pkg::S_DECODE: begin
            state_in = ctc_pkg::S_SEND;
            cmd.op   = ctc_pkg::OP_STATUS;
            case (stat.func)
               ctc_pkg::FUNC_CONVERT: begin
                  if (stat.mode == ctc_pkg::MODE_UNINIT) begin
                     cmd.code = ctc_pkg::STS_NOT_READY;
                  end else if (stat.mode != ctc_pkg::MODE_READY) begin
                     cmd.code = ctc_pkg::STS_UNAVAILABLE;
                  end else if (stat.below_base) begin
                     cmd.code = ctc_pkg::STS_BEFORE_BASE;
                  end else begin
                     cmd.op   = ctc_pkg::OP_MUL_CONV;
                     state_in = ctc_pkg::S_MUL;
                  end
               end
               ctc_pkg::FUNC_INIT: begin
                  if (stat.mode == ctc_pkg::MODE_READY) begin
                     cmd.code = ctc_pkg::STS_OK;
                  end else if (stat.mode != ctc_pkg::MODE_UNINIT) begin
                     cmd.code = ctc_pkg::STS_UNAVAILABLE;
                  end else if (stat.init_bad) begin
                     cmd.op = ctc_pkg::OP_FAIL;
                  end else begin
                     cmd.op   = ctc_pkg::OP_DIV_INIT;
                     state_in = ctc_pkg::S_DIV_SCALE;
                  end
               end
               ctc_pkg::FUNC_CALIB: begin
                  if (stat.mode == ctc_pkg::MODE_UNINIT) begin
                     cmd.code = ctc_pkg::STS_NOT_READY;
                  end else if (stat.mode != ctc_pkg::MODE_READY) begin
                     cmd.code = ctc_pkg::STS_UNAVAILABLE;
                  end else if (stat.below_due) begin
                     cmd.code = ctc_pkg::STS_NOT_DUE;
                  end else if (stat.sample_bad) begin
                     cmd.code = ctc_pkg::STS_REJECTED;
                  end else begin
                     cmd.op   = ctc_pkg::OP_MUL_CAL;
                     state_in = ctc_pkg::S_MUL;
                  end
               end
               default: begin
                  cmd.code = ctc_pkg::STS_REJECTED;
               end
            endcase
         end
         ctc_pkg::S_MUL: begin
            if (!stat.busy) begin
               state_in = (stat.func == ctc_pkg::FUNC_CONVERT) ? ctc_pkg::S_CONV
                                                                 : ctc_pkg::S_PRED;
            end
         end
         ctc_pkg::S_CONV: begin
            cmd.op   = ctc_pkg::OP_CONV_RES;
            state_in = ctc_pkg::S_SEND;
         end
         ctc_pkg::S_PRED: begin
            cmd.op   = ctc_pkg::OP_PRED;
            state_in = ctc_pkg::S_ERR;
         end
         ctc_pkg::S_ERR: begin
            cmd.op   = ctc_pkg::OP_ERR;
            state_in = ctc_pkg::S_CLAMP;
         end
         ctc_pkg::S_CLAMP: begin
            cmd.op   = ctc_pkg::OP_CLAMP;
            state_in = ctc_pkg::S_CORR;
         end
         ctc_pkg::S_CORR: begin
            cmd.op   = ctc_pkg::OP_CORR;
            state_in = ctc_pkg::S_CORR_CHK;
         end
         ctc_pkg::S_CORR_CHK: begin
            if (stat.corr_bad) begin
               cmd.op   = ctc_pkg::OP_STATUS;
               cmd.code = ctc_pkg::STS_REJECTED;
               state_in = ctc_pkg::S_SEND;
            end else begin
               cmd.op   = ctc_pkg::OP_DIV_CAL;
               state_in = ctc_pkg::S_DIV_SCALE;
            end
         end
         ctc_pkg::S_DIV_SCALE: begin
            if (!stat.busy) begin
               state_in = ctc_pkg::S_SCALE_CHK;
            end
         end
         ctc_pkg::S_SCALE_CHK: begin
            if (stat.quo_zero) begin
               state_in = ctc_pkg::S_SEND;
               if (stat.func == ctc_pkg::FUNC_INIT) begin
                  cmd.op = ctc_pkg::OP_FAIL;
               end else begin
                  cmd.op   = ctc_pkg::OP_STATUS;
                  cmd.code = ctc_pkg::STS_REJECTED;
               end
            end else begin
               state_in = ctc_pkg::S_DIV_DUE;
               cmd.op   = (stat.func == ctc_pkg::FUNC_INIT) ? ctc_pkg::OP_COMMIT_INIT
                                                              : ctc_pkg::OP_COMMIT_CAL;
            end
         end
         ctc_pkg::S_DIV_DUE: begin
            if (!stat.busy) begin
               state_in = ctc_pkg::S_DUE;
            end
         end
         ctc_pkg::S_DUE: begin
            cmd.op   = ctc_pkg::OP_DUE;
            state_in = ctc_pkg::S_SEND;
         end
         ctc_pkg::S_SEND: begin
            if (stat.rsp_free) begin
               cmd.op   = ctc_pkg::OP_SEND;
               state_in = ctc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ctc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/ctc_dp.sv =====
module ctc_dp #(
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctc_pkg::cmd_type                cmd,
   output ctc_pkg::stat_type               stat,
   input  logic [1:0]                      req_func,
   input  logic [63:0]                     req_counter,
   input  logic [63:0]                     req_first_count,
   input  logic [63:0]                     req_first_time,
   input  logic [63:0]                     req_sample_count,
   input  logic [63:0]                     req_sample_time,
   input  logic                            req_sample_ok,
   input  logic                            req_invariant_ok,
   input  logic                            csr_write_enable,
   input  logic [ctc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ctc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_time_ns,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_clock_ready
);

   // latched item
   logic [1:0]  func_ff;
   logic [63:0] counter_ff, fc_ff, ft_ff, sc_ff, st_ff;
   logic        sok_ff, inv_ff;

   // conversion state
   ctc_pkg::mode_type mode_ff;
   logic [63:0] base_count_ff, base_time_ff, scale_ff, last_error_ff, due_count_ff;

   // calibration scratch
   logic [63:0] pred_ff, err_ff, corr_ff;

   logic [ctc_pkg::MAX_ERROR_W-1:0] max_error_ff;
   logic [ctc_pkg::INTERVAL_W-1:0]  interval_ff;

   logic [63:0] res_time_ff;
   logic [2:0]  res_status_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_time_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_clock_ready_ff;

   logic        mul_start, div_start, mul_busy, div_busy;
   logic [63:0] mul_a, mul_b, mul_res, div_x, div_d, quo;
   logic [63:0] dt, dc, lim, neg_lim;

   assign dt      = st_ff - ft_ff;
   assign dc      = sc_ff - fc_ff;
   assign lim     = {{(64 - ctc_pkg::MAX_ERROR_W){1'b0}}, max_error_ff};
   assign neg_lim = 64'd0 - lim;

   always_comb begin
      mul_start = 1'b0;
      mul_a     = counter_ff - base_count_ff;
      mul_b     = scale_ff;
      div_start = 1'b0;
      div_x     = dt;
      div_d     = dc;
      case (cmd.op)
         ctc_pkg::OP_MUL_CONV: begin
            mul_start = 1'b1;
         end
         ctc_pkg::OP_MUL_CAL: begin
            mul_start = 1'b1;
            mul_a     = sc_ff - base_count_ff;
         end
         ctc_pkg::OP_DIV_INIT: begin
            div_start = 1'b1;
         end
         ctc_pkg::OP_DIV_CAL: begin
            div_start = 1'b1;
            div_x     = corr_ff;
            div_d     = sc_ff - base_count_ff;
         end
         ctc_pkg::OP_COMMIT_INIT, ctc_pkg::OP_COMMIT_CAL: begin
            div_start = 1'b1;
            div_x     = {{(64 - ctc_pkg::INTERVAL_W){1'b0}}, interval_ff};
            div_d     = quo;
         end
         default: begin
         end
      endcase
   end

   ctc_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .busy   (mul_busy),
      .result (mul_res)
   );

   ctc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .d     (div_d),
      .busy  (div_busy),
      .quo   (quo)
   );

   always_comb begin
      stat.func       = func_ff;
      stat.mode       = mode_ff;
      stat.below_base = (counter_ff < base_count_ff);
      stat.below_due  = (counter_ff < due_count_ff);
      stat.sample_bad = !sok_ff || (sc_ff <= base_count_ff);
      stat.init_bad   = !inv_ff || !sok_ff || (sc_ff <= fc_ff) || dt[63] || (dt == 64'd0);
      stat.corr_bad   = corr_ff[63] || (corr_ff == 64'd0);
      stat.quo_zero   = (quo == 64'd0);
      stat.busy       = mul_busy || div_busy;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_error_ff <= ctc_pkg::MAX_ERROR_RESET;
         interval_ff  <= ctc_pkg::INTERVAL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ctc_pkg::CSR_MAX_ERROR: max_error_ff <= csr_write_data[ctc_pkg::MAX_ERROR_W-1:0];
            ctc_pkg::CSR_INTERVAL:  interval_ff  <= csr_write_data[ctc_pkg::INTERVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ctc_pkg::OP_LATCH) begin
         func_ff    <= req_func;
         counter_ff <= req_counter;
         fc_ff      <= req_first_count;
         ft_ff      <= req_first_time;
         sc_ff      <= req_sample_count;
         st_ff      <= req_sample_time;
         sok_ff     <= req_sample_ok;
         inv_ff     <= req_invariant_ok;
      end
      case (cmd.op)
         ctc_pkg::OP_PRED: pred_ff <= base_time_ff + mul_res;
         ctc_pkg::OP_ERR:  err_ff  <= pred_ff - st_ff;
         ctc_pkg::OP_CLAMP: begin
            if ($signed(err_ff) > $signed(lim)) begin
               err_ff <= lim;
            end else if ($signed(err_ff) < $signed(neg_lim)) begin
               err_ff <= neg_lim;
            end
         end
         // elapsed time corrected by twice the error less the previous one
         ctc_pkg::OP_CORR: corr_ff <= mul_res - {err_ff[62:0], 1'b0} + last_error_ff;
         ctc_pkg::OP_CONV_RES: begin
            res_time_ff   <= base_time_ff + mul_res;
            res_status_ff <= ctc_pkg::STS_OK;
         end
         ctc_pkg::OP_STATUS: begin
            res_time_ff   <= 64'd0;
            res_status_ff <= cmd.code;
         end
         ctc_pkg::OP_FAIL: begin
            res_time_ff   <= 64'd0;
            res_status_ff <= ctc_pkg::STS_UNAVAILABLE;
         end
         ctc_pkg::OP_DUE: begin
            res_time_ff   <= 64'd0;
            res_status_ff <= ctc_pkg::STS_OK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ctc_pkg::MODE_UNINIT;
         base_count_ff <= 64'd0;
         base_time_ff  <= 64'd0;
         scale_ff      <= 64'd0;
         last_error_ff <= 64'd0;
         due_count_ff  <= 64'd0;
      end else begin
         case (cmd.op)
            ctc_pkg::OP_FAIL: mode_ff <= ctc_pkg::MODE_UNAVAIL;
            ctc_pkg::OP_COMMIT_INIT: begin
               base_count_ff <= fc_ff;
               base_time_ff  <= ft_ff;
               scale_ff      <= quo;
               last_error_ff <= 64'd0;
               mode_ff       <= ctc_pkg::MODE_READY;
            end
            ctc_pkg::OP_COMMIT_CAL: begin
               base_count_ff <= sc_ff;
               base_time_ff  <= pred_ff;
               scale_ff      <= quo;
               last_error_ff <= err_ff;
            end
            ctc_pkg::OP_DUE: due_count_ff <= sc_ff + quo;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == ctc_pkg::OP_SEND) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == ctc_pkg::OP_SEND) begin
         rsp_time_ff        <= res_time_ff;
         rsp_status_ff      <= res_status_ff;
         rsp_clock_ready_ff <= (mode_ff == ctc_pkg::MODE_READY);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_time_ns     = rsp_time_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_clock_ready = rsp_clock_ready_ff;

endmodule

// ===== hdl/counter_time_conversion_calibrator.sv =====
// Cycle count to nanosecond converter with self-calibration.
// req_ch carries one command per transfer: convert a count, initialize the
// scale from two reference pairs, or calibrate against a fresh pair.
// rsp_ch returns exactly one result per command: time_ns (non-zero only for a
// successful convert), status and clock_ready (scale valid after the command).
// csr_* writes max_error_ns (index 0) or interval_ns (index 1); write only
// while no command is in flight.
// One command at a time. Work from request transfer to response valid:
//   status-only answers           no arithmetic
//   convert                       64-step shift-add multiply
//   initialize                    two 128-step divisions
//   calibrate                     multiply, then two divisions
// The bit-serial multiplier and divider do this work. req_ch.ready is high
// whenever no command is in flight, even while a response still waits in the
// output register; a stalled receiver holds the response and stops the next
// command only at its response stage. Reset returns the block to uninitialized
// with config registers at their defaults; no clearing pass is needed.
module counter_time_conversion_calibrator #(
   parameter int unsigned FRACTION_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   ctc_req_if.sink                         req_ch,
   ctc_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [ctc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ctc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   ctc_pkg::cmd_type  cmd;
   ctc_pkg::stat_type stat;
   logic [63:0]       time_raw;

   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ctc_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_ch.func),
      .req_counter      (req_ch.counter),
      .req_first_count  (req_ch.first_count),
      .req_first_time   (req_ch.first_time),
      .req_sample_count (req_ch.sample_count),
      .req_sample_time  (req_ch.sample_time),
      .req_sample_ok    (req_ch.sample_ok),
      .req_invariant_ok (req_ch.invariant_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_time_ns      (time_raw),
      .rsp_status       (rsp_ch.status),
      .rsp_clock_ready  (rsp_ch.clock_ready)
   );

   assign rsp_ch.time_ns = $signed(time_raw);

endmodule

// ===== hdl/ctc_checker.sv =====
module ctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] time_ns,
   input logic [2:0]  status,
   input logic        clock_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != ctc_pkg::STS_OK) |-> (time_ns == 64'd0))
      else $error("non-zero time on a failed command");

   a_ready_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && clock_ready |->
         (status != ctc_pkg::STS_NOT_READY) && (status != ctc_pkg::STS_UNAVAILABLE))
      else $error("clock_ready contradicts status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

endmodule

bind counter_time_conversion_calibrator ctc_checker u_ctc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .time_ns     (rsp_ch.time_ns),
   .status      (rsp_ch.status),
   .clock_ready (rsp_ch.clock_ready)
);

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAC = 32;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] counter;
      logic [63:0] first_count;
      logic [63:0] first_time;
      logic [63:0] sample_count;
      logic [63:0] sample_time;
      logic        sample_ok;
      logic        invariant_ok;
   } command_type;

   typedef struct packed {
      logic [63:0] time_ns;
      logic [2:0]  status;
      logic        clock_ready;
   } answer_type;

   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[FRAC+63:FRAC];
   endfunction

   function automatic logic [63:0] fixed_quotient(logic [63:0] x, logic [63:0] d);
      logic [127:0] n;
      n = {64'd0, x} << FRAC;
      n = n / {64'd0, d};
      return n[63:0];
   endfunction

   function automatic logic [63:0] rate_from(logic [63:0] ns, logic [63:0] cnt);
      if ($signed(ns) <= 0 || cnt == 0)
         return 64'd0;
      return fixed_quotient(ns, cnt);
   endfunction

   // Tracks the calibrator's state and holds the answers still owed by it
   class conversion_predictor;
      logic [29:0]       max_error;
      logic [39:0]       interval;
      ctc_pkg::mode_type mode;
      logic [63:0]       base_count, base_time, scale, last_error, due_count;
      answer_type        owed[$];
      int                errors;
      int                per_status[8];
      int                accepted;

      function new();
         max_error  = ctc_pkg::MAX_ERROR_RESET;
         interval   = ctc_pkg::INTERVAL_RESET;
         mode       = ctc_pkg::MODE_UNINIT;
         base_count = 0;
         base_time  = 0;
         scale      = 0;
         last_error = 0;
         due_count  = 0;
         errors     = 0;
         accepted   = 0;
         foreach (per_status[i]) per_status[i] = 0;
      endfunction

      function void write_reg(logic [ctc_pkg::CSR_INDEX_W-1:0] idx, logic [39:0] data);
         if (idx == ctc_pkg::CSR_MAX_ERROR)
            max_error = data[29:0];
         else
            interval = data;
      endfunction

      function void note_command(command_type c);
         answer_type  a;
         logic [63:0] s, predicted, err_u, corrected, dc;
         logic signed [63:0] err, lim;
         a = '0;
         a.status = ctc_pkg::STS_OK;
         case (c.func)
            ctc_pkg::FUNC_CONVERT: begin
               if (mode == ctc_pkg::MODE_UNINIT)
                  a.status = ctc_pkg::STS_NOT_READY;
               else if (mode != ctc_pkg::MODE_READY)
                  a.status = ctc_pkg::STS_UNAVAILABLE;
               else if (c.counter < base_count)
                  a.status = ctc_pkg::STS_BEFORE_BASE;
               else
                  a.time_ns = base_time + scaled_product(c.counter - base_count, scale);
            end
            ctc_pkg::FUNC_INIT: begin
               if (mode == ctc_pkg::MODE_READY)
                  a.status = ctc_pkg::STS_OK;
               else if (mode != ctc_pkg::MODE_UNINIT)
                  a.status = ctc_pkg::STS_UNAVAILABLE;
               else begin
                  s = 0;
                  if (c.invariant_ok && c.sample_ok && c.sample_count > c.first_count)
                     s = rate_from(c.sample_time - c.first_time,
                                   c.sample_count - c.first_count);
                  if (s == 0) begin
                     mode = ctc_pkg::MODE_UNAVAIL;
                     a.status = ctc_pkg::STS_UNAVAILABLE;
                  end else begin
                     base_count = c.first_count;
                     base_time  = c.first_time;
                     scale      = s;
                     last_error = 0;
                     due_count  = c.sample_count + fixed_quotient({24'd0, interval}, s);
                     mode       = ctc_pkg::MODE_READY;
                  end
               end
            end
            ctc_pkg::FUNC_CALIB: begin
               if (mode == ctc_pkg::MODE_UNINIT)
                  a.status = ctc_pkg::STS_NOT_READY;
               else if (mode != ctc_pkg::MODE_READY)
                  a.status = ctc_pkg::STS_UNAVAILABLE;
               else if (c.counter < due_count)
                  a.status = ctc_pkg::STS_NOT_DUE;
               else if (!c.sample_ok || c.sample_count <= base_count)
                  a.status = ctc_pkg::STS_REJECTED;
               else begin
                  dc        = c.sample_count - base_count;
                  predicted = base_time + scaled_product(dc, scale);
                  err       = $signed(predicted - c.sample_time);
                  lim       = $signed({34'd0, max_error});
                  if (err > lim)
                     err = lim;
                  else if (err < -lim)
                     err = -lim;
                  err_u     = err;
                  corrected = (predicted - base_time) - (err_u * 2 - last_error);
                  s         = rate_from(corrected, dc);
                  if (s == 0)
                     a.status = ctc_pkg::STS_REJECTED;
                  else begin
                     base_count = c.sample_count;
                     base_time  = predicted;
                     scale      = s;
                     last_error = err_u;
                     due_count  = c.sample_count + fixed_quotient({24'd0, interval}, s);
                  end
               end
            end
            default: a.status = ctc_pkg::STS_REJECTED;
         endcase
         a.clock_ready = (mode == ctc_pkg::MODE_READY);
         per_status[a.status]++;
         accepted++;
         owed.push_back(a);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result time_ns=%0d status=%0d clock_ready=%0b",
                     $time, $signed(got.time_ns), got.status, got.clock_ready);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.time_ns !== want.time_ns) begin
            $display("%0t: time_ns expected %0d actual %0d", $time,
                     $signed(want.time_ns), $signed(got.time_ns));
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.clock_ready !== want.clock_ready) begin
            $display("%0t: clock_ready expected %0b actual %0b", $time,
                     want.clock_ready, got.clock_ready);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                            csr_write_enable;
   logic [ctc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ctc_pkg::CSR_DATA_W-1:0]  csr_write_data;
   bit                              steady;

   ctc_req_if req_ch();
   ctc_rsp_if rsp_ch();

   conversion_predictor tracker = new();

   counter_time_conversion_calibrator dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // valid stays up after a transfer; the block holds ready low for a while
   task automatic send_command(command_type c);
      int gap;
      gap = gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= c.func;
      req_ch.counter      <= c.counter;
      req_ch.first_count  <= c.first_count;
      req_ch.first_time   <= c.first_time;
      req_ch.sample_count <= c.sample_count;
      req_ch.sample_time  <= c.sample_time;
      req_ch.sample_ok    <= c.sample_ok;
      req_ch.invariant_ok <= c.invariant_ok;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_command(c);
   endtask

   task automatic write_reg(logic [ctc_pkg::CSR_INDEX_W-1:0] idx, logic [39:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly calibrations that are due and close to the predicted time
   function automatic command_type random_command();
      command_type c;
      int          r;
      logic [63:0] dc, noise;
      c.func         = ctc_pkg::FUNC_CALIB;
      c.counter      = rand64();
      c.first_count  = rand64();
      c.first_time   = rand64();
      c.sample_count = rand64();
      c.sample_time  = rand64();
      c.sample_ok    = ($urandom_range(0, 19) != 0);
      c.invariant_ok = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 60) begin
         dc = $urandom_range(1, 1 << $urandom_range(1, 26));
         if ($urandom_range(0, 9) == 0) dc = rand64() >> $urandom_range(0, 40);
         noise = $signed($urandom_range(0, 1 << $urandom_range(1, 30)))
                 - $signed(64'd1 << $urandom_range(0, 29));
         c.sample_count = tracker.base_count + dc;
         c.sample_time  = tracker.base_time + scaled_product(dc, tracker.scale) + noise;
         c.counter      = tracker.due_count + $urandom_range(0, 2000);
         if ($urandom_range(0, 9) == 0) c.counter = tracker.due_count - 1;
      end else if (r < 85) begin
         c.func = ctc_pkg::FUNC_CONVERT;
         c.counter = tracker.base_count + ($urandom_range(0, 3) == 0 ? rand64()
                     : 64'($urandom));
         if ($urandom_range(0, 9) == 0) c.counter = tracker.base_count - $urandom_range(1, 9);
      end else if (r < 92) begin
         c.func = ctc_pkg::FUNC_INIT;
      end else if (r < 96) begin
         c.func = ctc_pkg::FUNC_UNUSED;
      end
      return c;
   endfunction

   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall = gap_length();
            rsp_ch.ready <= (stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_answer({rsp_ch.time_ns, rsp_ch.status, rsp_ch.clock_ready});
   end

   initial begin
      #60ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      command_type c;
      logic [63:0] dc;
      logic [29:0] err_set[6];
      logic [39:0] int_set[6];
      err_set = '{30'd0, 30'd1000000000, 30'd5000, 30'd1, 30'd20000000, 30'd300};
      int_set = '{40'd1, 40'hFF_FFFF_FFFF, 40'd100000, 40'd3000000000, 40'd777, 40'd5000000};
      steady = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.func = ctc_pkg::FUNC_CONVERT;
      req_ch.counter = '0;
      req_ch.first_count = '0;
      req_ch.first_time = '0;
      req_ch.sample_count = '0;
      req_ch.sample_time = '0;
      req_ch.sample_ok = 1'b0;
      req_ch.invariant_ok = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // before initialize: convert and calibrate answer not ready, the unused code rejected
      c = '0;
      c.func = ctc_pkg::FUNC_CONVERT; c.counter = '1; send_command(c);
      c.func = ctc_pkg::FUNC_CALIB; c.counter = '1; c.sample_ok = 1'b1; send_command(c);
      c.func = ctc_pkg::FUNC_UNUSED; send_command(c);

      // successful initialize at default registers, roughly 1.5 ns per count
      c = '0;
      c.func = ctc_pkg::FUNC_INIT;
      c.first_count  = 64'hFFFF_FF00_0000_0000 + $urandom;
      c.first_time   = -64'sd1000000000;
      dc = 64'd2000000;
      c.sample_count = c.first_count + dc;
      c.sample_time  = c.first_time + 64'd3000123;
      c.sample_ok    = 1'b1;
      c.invariant_ok = 1'b1;
      send_command(c);
      // initialize again while ready changes nothing
      c.first_count = '1; c.first_time = 64'h8000_0000_0000_0000;
      c.sample_count = '0; c.sample_time = 64'h7FFF_FFFF_FFFF_FFFF;
      send_command(c);

      c = '0;
      c.func = ctc_pkg::FUNC_CONVERT;
      c.counter = tracker.base_count - 1; send_command(c);
      c.counter = tracker.base_count; send_command(c);
      c.counter = '1; send_command(c);
      c.func = ctc_pkg::FUNC_CALIB;
      c.counter = tracker.due_count - 1; c.sample_ok = 1'b1;
      c.sample_count = tracker.base_count + 10; send_command(c);
      c.counter = '1; c.sample_ok = 1'b0; send_command(c);
      c.sample_ok = 1'b1; c.sample_count = tracker.base_count; send_command(c);
      c.sample_count = tracker.base_count + 64'd1000;
      c.sample_time = 64'h8000_0000_0000_0000; send_command(c);
      c.counter = tracker.due_count;
      c.sample_count = tracker.base_count + 64'd4000000;
      c.sample_time = 64'h7FFF_FFFF_FFFF_FFFF; send_command(c);
      c.counter = tracker.due_count;
      c.sample_count = tracker.base_count + 64'd4000000;
      c.sample_time = tracker.base_time + scaled_product(64'd4000000, tracker.scale)
                      + 64'd777;
      send_command(c);
      c.func = ctc_pkg::FUNC_UNUSED; send_command(c);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         write_reg(ctc_pkg::CSR_MAX_ERROR, {10'd0, err_set[phase]});
         write_reg(ctc_pkg::CSR_INTERVAL, int_set[phase]);
         steady = (phase == 2);
         for (int n = 0; n < 270; n++)
            send_command(random_command());
      end
      steady = 1'b0;

      drain();
      repeat (400) @(posedge clock);
      $display("Covered %0d commands over six register settings: ok %0d, not ready %0d,",
               tracker.accepted, tracker.per_status[ctc_pkg::STS_OK],
               tracker.per_status[ctc_pkg::STS_NOT_READY]);
      $display("  before base %0d, not due %0d, rejected %0d",
               tracker.per_status[ctc_pkg::STS_BEFORE_BASE],
               tracker.per_status[ctc_pkg::STS_NOT_DUE],
               tracker.per_status[ctc_pkg::STS_REJECTED]);
      if (tracker.errors == 0 && tracker.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
